// File: rtl/lppr_pkg.sv
// ----------------------------------------------------------------------------
// Packet ring package
// Operation and status codes, header constants and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lppr_pkg;

	localparam int unsigned LEN_W      = 12;
	localparam int unsigned HDR_BYTES  = 4;
	localparam int unsigned HDR_IDX_W  = 2;

	typedef enum logic [1:0] {
		OP_PUSH_HDR  = 2'd0,
		OP_PUSH_DATA = 2'd1,
		OP_POP_HDR   = 2'd2,
		OP_POP_DATA  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL    = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_SMALL   = 3'd4,
		ST_SEQ     = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 accept;
		logic                 hdr_wr;
		logic [HDR_IDX_W-1:0] hdr_idx;
		logic                 rd_hdr;
		logic                 rd_hdr_hi;
		logic                 hdr_eval;
		logic                 data_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hdr_fits;
		logic ring_nonempty;
		logic rd_open;
	} stat_t;

endpackage

// File: rtl/lppr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lppr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/lppr_ctrl.sv
// ----------------------------------------------------------------------------
// Packet ring controller
// Sequences header writes, header reads and payload reads, and raises the
// result strobe once per accepted item.
// ----------------------------------------------------------------------------
module lppr_ctrl
	import lppr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] operation,
	input  stat_t      stat,
	output logic       busy,
	output logic       done,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_WR,
		S_RD0,
		S_RD1,
		S_RD_CHK,
		S_DATA_OUT
	} state_t;

	state_t               state_q;
	logic [HDR_IDX_W-1:0] idx_q;
	logic                 done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd         = '0;
		cmd.accept  = start && (state_q == S_IDLE);
		cmd.hdr_idx = idx_q;
		case (state_q)
			S_HDR_WR:   cmd.hdr_wr = 1'b1;
			S_RD0:      cmd.rd_hdr = 1'b1;
			S_RD1: begin
				cmd.rd_hdr    = 1'b1;
				cmd.rd_hdr_hi = 1'b1;
			end
			S_RD_CHK:   cmd.hdr_eval = 1'b1;
			S_DATA_OUT: cmd.data_out = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op_t'(operation))
							OP_PUSH_HDR: begin
								// The result goes out at once; the header bytes follow.
								done_q <= 1'b1;
								if (stat.hdr_fits) begin
									state_q <= S_HDR_WR;
									idx_q   <= '0;
								end
							end
							OP_PUSH_DATA: done_q <= 1'b1;
							OP_POP_HDR: begin
								if (stat.ring_nonempty) begin
									state_q <= S_RD0;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_POP_DATA: begin
								if (stat.rd_open) begin
									state_q <= S_DATA_OUT;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_HDR_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == HDR_IDX_W'(HDR_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_RD0:    state_q <= S_RD1;
				S_RD1:    state_q <= S_RD_CHK;
				S_RD_CHK: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DATA_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/lppr_dp.sv
// ----------------------------------------------------------------------------
// Packet ring datapath
// Ring pointers, fill level, open-record cursors, the byte store and the
// result registers.
// ----------------------------------------------------------------------------
module lppr_dp
	import lppr_pkg::*;
#(
	parameter int unsigned CAPACITY = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       operation,
	input  logic [LEN_W-1:0] in_length,
	input  logic [7:0]       in_byte,
	input  cmd_t             cmd,
	output stat_t            stat,
	output status_t          out_status,
	output logic [7:0]       out_byte,
	output logic [LEN_W-1:0] out_length,
	output logic             out_last
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned UW = $clog2(CAPACITY + 1);
	localparam int unsigned FW = ((UW > LEN_W) ? UW : LEN_W) + 2;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos, input logic [2:0] k);
		logic [AW:0] s;
		s = {1'b0, pos} + (AW+1)'(k);
		if (s >= (AW+1)'(CAPACITY)) begin
			s = s - (AW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	// Control state.
	logic [AW-1:0]    write_pos_q;
	logic [AW-1:0]    read_pos_q;
	logic [AW-1:0]    write_cursor_q;
	logic [AW-1:0]    read_cursor_q;
	logic [UW-1:0]    used_q;
	logic [LEN_W-1:0] write_left_q;
	logic [LEN_W-1:0] read_left_q;

	// Payload state.
	logic [LEN_W-1:0] wlen_q;
	logic [LEN_W-1:0] rlen_q;
	logic [LEN_W-1:0] limit_q;
	logic [7:0]       hdr_lo_q;

	op_t              op;
	logic [FW-1:0]    fit_sum;
	logic             hdr_fits;
	logic [LEN_W-1:0] stored;
	logic             hdr_too_big;
	logic [AW-1:0]    wr_next;
	logic [AW-1:0]    rd_next;
	logic [AW-1:0]    wr_body;
	logic [AW-1:0]    rd_body;
	logic [FW-1:0]    push_total;
	logic [UW-1:0]    push_used;
	logic [FW-1:0]    pop_total;
	logic [FW-1:0]    pop_diff;
	logic [UW-1:0]    pop_used;
	logic [UW-1:0]    skip_used;
	logic             push_data_go;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [7:0]       ram_rdata;

	assign op          = op_t'(operation);
	assign fit_sum     = FW'(used_q) + FW'(HDR_BYTES) + FW'(in_length);
	assign hdr_fits    = (in_length != '0) && (fit_sum <= FW'(CAPACITY));
	// Committed headers never exceed twelve bits, so the upper header bytes are not read.
	assign stored      = {ram_rdata[3:0], hdr_lo_q};
	assign hdr_too_big = stored > limit_q;
	assign wr_next     = wrap_add(write_cursor_q, 3'd1);
	assign rd_next     = wrap_add(read_cursor_q, 3'd1);
	assign wr_body     = wrap_add(write_pos_q, 3'(HDR_BYTES));
	assign rd_body     = wrap_add(read_pos_q, 3'(HDR_BYTES));

	assign push_total = FW'(used_q) + FW'(HDR_BYTES) + FW'(wlen_q);
	assign push_used  = (push_total > FW'(CAPACITY)) ? UW'(CAPACITY) : push_total[UW-1:0];
	assign pop_total  = FW'(HDR_BYTES) + FW'(rlen_q);
	assign pop_diff   = FW'(used_q) - pop_total;
	assign pop_used   = (FW'(used_q) > pop_total) ? pop_diff[UW-1:0] : '0;
	assign skip_used  = (used_q > UW'(HDR_BYTES)) ? (used_q - UW'(HDR_BYTES)) : '0;

	assign stat.hdr_fits      = hdr_fits;
	assign stat.ring_nonempty = (used_q != '0);
	assign stat.rd_open       = (read_left_q != '0);

	assign push_data_go = cmd.accept && (op == OP_PUSH_DATA) && (write_left_q != '0);

	always_comb begin
		ram_we    = push_data_go || cmd.hdr_wr;
		ram_waddr = write_cursor_q;
		ram_wdata = in_byte;
		if (cmd.hdr_wr) begin
			ram_waddr = wrap_add(write_pos_q, 3'(cmd.hdr_idx));
			case (cmd.hdr_idx)
				2'd0:    ram_wdata = wlen_q[7:0];
				2'd1:    ram_wdata = 8'(wlen_q[LEN_W-1:8]);
				default: ram_wdata = '0;
			endcase
		end
	end

	// When idle the read port points at the read cursor, so a payload byte is
	// already on its way when a pop data transfer is taken.
	always_comb begin
		if (cmd.rd_hdr) begin
			ram_raddr = cmd.rd_hdr_hi ? wrap_add(read_pos_q, 3'd1) : read_pos_q;
		end else begin
			ram_raddr = read_cursor_q;
		end
	end

	lppr_ram #(
		.WIDTH(8),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q    <= '0;
			read_pos_q     <= '0;
			write_cursor_q <= '0;
			read_cursor_q  <= '0;
			used_q         <= '0;
			write_left_q   <= '0;
			read_left_q    <= '0;
		end else begin
			if (cmd.accept) begin
				case (op)
					OP_PUSH_HDR: begin
						// A new header abandons any record still being written.
						write_left_q <= '0;
						if (hdr_fits) begin
							write_cursor_q <= wr_body;
							write_left_q   <= in_length;
						end
					end
					OP_PUSH_DATA: begin
						if (write_left_q != '0) begin
							write_cursor_q <= wr_next;
							write_left_q   <= write_left_q - 1'b1;
							if (write_left_q == LEN_W'(1)) begin
								write_pos_q <= wr_next;
								used_q      <= push_used;
							end
						end
					end
					OP_POP_HDR:  read_left_q <= '0;
					default: ;
				endcase
			end
			if (cmd.hdr_eval && !hdr_too_big) begin
				read_cursor_q <= rd_body;
				read_left_q   <= stored;
				if (stored == '0) begin
					read_pos_q <= rd_body;
					used_q     <= skip_used;
				end
			end
			if (cmd.data_out) begin
				read_cursor_q <= rd_next;
				read_left_q   <= read_left_q - 1'b1;
				if (read_left_q == LEN_W'(1)) begin
					read_pos_q <= rd_next;
					used_q     <= pop_used;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			limit_q    <= in_length;
			out_byte   <= '0;
			out_length <= '0;
			out_last   <= 1'b0;
			out_status <= ST_OK;
			case (op)
				OP_PUSH_HDR: begin
					wlen_q <= in_length;
					if (in_length == '0) begin
						out_status <= ST_INVALID;
					end else if (!hdr_fits) begin
						out_status <= ST_FULL;
					end
				end
				OP_PUSH_DATA: begin
					if (write_left_q == '0) begin
						out_status <= ST_SEQ;
					end else begin
						out_last <= (write_left_q == LEN_W'(1));
					end
				end
				OP_POP_HDR: begin
					if (used_q == '0) begin
						out_status <= ST_EMPTY;
					end
				end
				OP_POP_DATA: begin
					if (read_left_q == '0) begin
						out_status <= ST_SEQ;
					end
				end
				default: ;
			endcase
		end
		if (cmd.rd_hdr_hi) begin
			hdr_lo_q <= ram_rdata;
		end
		if (cmd.hdr_eval) begin
			rlen_q     <= stored;
			out_byte   <= '0;
			out_last   <= 1'b0;
			out_status <= hdr_too_big ? ST_SMALL : ST_OK;
			out_length <= hdr_too_big ? '0 : stored;
		end
		if (cmd.data_out) begin
			out_status <= ST_OK;
			out_byte   <= ram_rdata;
			out_length <= '0;
			out_last   <= (read_left_q == LEN_W'(1));
		end
	end

endmodule

// File: rtl/length_prefixed_packet_ring_core.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet ring core
// A byte ring holding variable-length records, each a four-byte length header
// followed by its payload, pushed and popped one byte transfer at a time.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on done for one cycle and cannot be held off. A push data item
// never sets busy, so payload can be written every cycle. A pop data item
// on an open record holds busy in S_DATA_OUT for the registered store read.
// A rejected push header leaves busy low; an accepted one holds it while the
// four header bytes are written through the single write port. A pop header
// leaves busy low on an empty ring, else steps through S_RD0, S_RD1, S_RD_CHK,
// reading the two low header bytes in turn. The store needs no clearing after reset.
module length_prefixed_packet_ring_core
	import lppr_pkg::*;
#(
	parameter int unsigned CAPACITY = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  logic [1:0]       operation,
	input  logic [LEN_W-1:0] in_length,
	input  logic [7:0]       in_byte,
	output logic [2:0]       out_status,
	output logic [7:0]       out_byte,
	output logic [LEN_W-1:0] out_length,
	output logic             out_last
);

	cmd_t    cmd;
	stat_t   stat;
	status_t dp_status;
	logic    accept;

	assign accept     = start && !busy;
	assign out_status = dp_status;

	lppr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.stat     (stat),
		.busy     (busy),
		.done     (done),
		.cmd      (cmd)
	);

	lppr_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.operation (operation),
		.in_length (in_length),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.stat      (stat),
		.out_status(dp_status),
		.out_byte  (out_byte),
		.out_length(out_length),
		.out_last  (out_last)
	);

	// A push data transfer always answers in the following cycle.
	a_push_data_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_PUSH_DATA) |=> done)
		else $error("push data result missing");

	// The end-of-record mark only accompanies a successful data transfer.
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_last |-> (out_status == ST_OK))
		else $error("last marker on a failed item");

	// A failed item returns no length and no byte.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (out_status != ST_OK) |-> (out_length == '0) && (out_byte == '0))
		else $error("failed item carries payload");

	// A pop header either answers at once or leaves the block busy for the header read.
	a_pop_hdr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_POP_HDR) |=> (busy || done))
		else $error("pop header neither answered nor in progress");

endmodule

// File: verif/lppr_reply_checker.sv
// ----------------------------------------------------------------------------
// Packet ring reply checker
// Watches the command and reply channels of the packet ring core. It keeps its
// own copy of the ring and its cursors, works out the reply that every
// accepted transfer must produce, and compares each reply as it arrives.
// ----------------------------------------------------------------------------
module lppr_reply_checker
	import lppr_pkg::*;
#(
	parameter int unsigned CAPACITY = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             done,
	input  logic [1:0]       operation,
	input  logic [LEN_W-1:0] in_length,
	input  logic [7:0]       in_byte,
	input  logic [2:0]       out_status,
	input  logic [7:0]       out_byte,
	input  logic [LEN_W-1:0] out_length,
	input  logic             out_last,
	output int unsigned      mismatches,
	output int unsigned      replies_waiting,
	output int unsigned      replies_checked
);

	localparam int unsigned POS_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = POS_W + 1;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data;
		logic [LEN_W-1:0] rec_len;
		logic             last;
	} ring_reply_t;

	logic [7:0]       ring_mem [CAPACITY];
	logic [POS_W-1:0] wr_head, rd_tail, wr_ptr, rd_ptr;
	logic [CNT_W-1:0] fill_bytes, wr_remaining, rd_remaining;
	ring_reply_t      replies_due [$];
	ring_reply_t      want;

	function automatic logic [POS_W-1:0] wrap_pos(input int unsigned pos, input int unsigned n);
		return POS_W'((pos + n) % CAPACITY);
	endfunction

	// Length headers are stored little-endian, one byte per ring slot.
	function automatic logic [31:0] header_at(input logic [POS_W-1:0] pos);
		logic [31:0] v;
		int unsigned i;
		v = '0;
		for (i = 0; i < HDR_BYTES; i++)
			v |= 32'(ring_mem[wrap_pos(pos, i)]) << (8 * i);
		return v;
	endfunction

	function automatic ring_reply_t apply_ring_op(input op_t op, input logic [LEN_W-1:0] len,
			input logic [7:0] data_in);
		ring_reply_t r;
		int unsigned total, stored, i;
		r = '{status: ST_OK, data: '0, rec_len: '0, last: 1'b0};
		case (op)
			OP_PUSH_HDR: begin
				// Any record still open on the write side is dropped here.
				wr_remaining = '0;
				total = fill_bytes + HDR_BYTES + len;
				if (len == 0) begin
					r.status = ST_INVALID;
				end else if (total > CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = 0; i < HDR_BYTES; i++)
						ring_mem[wrap_pos(wr_head, i)] = 8'(32'(len) >> (8 * i));
					wr_ptr = wrap_pos(wr_head, HDR_BYTES);
					wr_remaining = CNT_W'(len);
				end
			end
			OP_PUSH_DATA: begin
				if (wr_remaining == 0) begin
					r.status = ST_SEQ;
				end else begin
					ring_mem[wr_ptr] = data_in;
					wr_ptr = wrap_pos(wr_ptr, 1);
					wr_remaining--;
					if (wr_remaining == 0) begin
						r.last = 1'b1;
						total = fill_bytes + HDR_BYTES + header_at(wr_head);
						wr_head = wr_ptr;
						fill_bytes = CNT_W'((total > CAPACITY) ? CAPACITY : total);
					end
				end
			end
			OP_POP_HDR: begin
				rd_remaining = '0;
				if (fill_bytes == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stored = header_at(rd_tail);
					if (stored > len) begin
						r.status = ST_SMALL;
					end else begin
						r.rec_len = LEN_W'(stored);
						rd_ptr = wrap_pos(rd_tail, HDR_BYTES);
						rd_remaining = CNT_W'(stored);
						if (stored == 0) begin
							rd_tail = rd_ptr;
							fill_bytes = (fill_bytes > HDR_BYTES) ?
								CNT_W'(fill_bytes - HDR_BYTES) : '0;
						end
					end
				end
			end
			default: begin
				if (rd_remaining == 0) begin
					r.status = ST_SEQ;
				end else begin
					r.data = ring_mem[rd_ptr];
					rd_ptr = wrap_pos(rd_ptr, 1);
					rd_remaining--;
					// The tail only moves once the final payload byte has gone.
					if (rd_remaining == 0) begin
						r.last = 1'b1;
						total = HDR_BYTES + header_at(rd_tail);
						rd_tail = rd_ptr;
						fill_bytes = (fill_bytes > total) ? CNT_W'(fill_bytes - total) : '0;
					end
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_head = '0;
			rd_tail = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			fill_bytes = '0;
			wr_remaining = '0;
			rd_remaining = '0;
			replies_due.delete();
			mismatches = 0;
			replies_waiting = 0;
			replies_checked = 0;
		end else begin
			// A reply seen at the same edge as a new transfer belongs to an older one,
			// so queueing first leaves the order intact.
			if (start && !busy)
				replies_due.push_back(apply_ring_op(op_t'(operation), in_length, in_byte));
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("reply with no transfer outstanding: out_status %0d", out_status);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (out_status !== want.status) begin
						$error("out_status: expected %0d, actual %0d", want.status, out_status);
						mismatches++;
					end
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0d, actual %0d", want.data, out_byte);
						mismatches++;
					end
					if (out_length !== want.rec_len) begin
						$error("out_length: expected %0d, actual %0d", want.rec_len, out_length);
						mismatches++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %0d, actual %0d", want.last, out_last);
						mismatches++;
					end
					replies_checked++;
				end
			end
			replies_waiting = replies_due.size();
		end
	end

endmodule

// File: verif/length_prefixed_packet_ring_core_tb.sv
// ----------------------------------------------------------------------------
// Packet ring core testbench
// Drives record pushes and pops into the packet ring core, first a short
// directed sequence through every status, then random well-formed records
// mixed with stray, truncated and rejected transfers, with random idle gaps.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_core_tb;
	import lppr_pkg::*;

	localparam int unsigned RING_BYTES   = 4096;
	localparam int unsigned RANDOM_ITEMS = 750;
	localparam int unsigned MAX_LEN      = 4092;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       operation = OP_PUSH_HDR;
	logic [LEN_W-1:0] in_length = '0;
	logic [7:0]       in_byte = '0;
	logic             busy, done, out_last;
	logic [2:0]       out_status;
	logic [7:0]       out_byte;
	logic [LEN_W-1:0] out_length;
	int unsigned      mismatches, replies_waiting, replies_checked;

	// Stimulus-side bookkeeping, used to shape the traffic and for the closing summary.
	int unsigned rec_lengths [$];
	int unsigned fill_est = 0;
	bit          wr_open = 1'b0;
	bit          rd_open = 1'b0;
	int unsigned items_sent = 0;
	int unsigned records_pushed = 0;
	int unsigned records_popped = 0;
	bit          burst = 1'b0;
	int unsigned burst_left = 0;

	length_prefixed_packet_ring_core #(
		.CAPACITY(RING_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.operation(operation),
		.in_length(in_length),
		.in_byte(in_byte),
		.out_status(out_status),
		.out_byte(out_byte),
		.out_length(out_length),
		.out_last(out_last)
	);

	lppr_reply_checker #(
		.CAPACITY(RING_BYTES)
	) reply_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.operation(operation),
		.in_length(in_length),
		.in_byte(in_byte),
		.out_status(out_status),
		.out_byte(out_byte),
		.out_length(out_length),
		.out_last(out_last),
		.mismatches(mismatches),
		.replies_waiting(replies_waiting),
		.replies_checked(replies_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$error("run did not complete in the time allowed");
		$display("*** FAILED ***");
		$finish;
	end

	// Called just after a rising edge; returns just after the edge that takes the transfer.
	task automatic send_item(input op_t op, input int unsigned len, input logic [7:0] data_in);
		int unsigned gap;
		if (burst_left == 0) begin
			burst = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(10, 60);
		end
		burst_left--;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		in_length <= LEN_W'(len);
		in_byte <= data_in;
		// busy is settled by the falling edge, so the next rising edge takes the transfer.
		do @(negedge clk); while (busy);
		@(posedge clk);
		items_sent++;
	endtask

	initial begin
		int unsigned directed_items, pick, rec_len, n_data, k, len_min, drain;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_POP_HDR, MAX_LEN, 8'h00);
		send_item(OP_PUSH_DATA, 0, 8'h5a);
		send_item(OP_POP_DATA, 0, 8'h00);
		send_item(OP_PUSH_HDR, 0, 8'h00);
		// A header that fills the ring exactly, then dropped by a short record.
		send_item(OP_PUSH_HDR, MAX_LEN, 8'h00);
		send_item(OP_PUSH_HDR, 1, 8'h00);
		send_item(OP_PUSH_DATA, 0, 8'hff);
		send_item(OP_PUSH_HDR, MAX_LEN, 8'h00);
		send_item(OP_PUSH_DATA, 0, 8'h11);
		send_item(OP_PUSH_HDR, RING_BYTES - 9, 8'h00);
		send_item(OP_PUSH_HDR, 2, 8'h00);
		send_item(OP_PUSH_DATA, MAX_LEN, 8'h00);
		send_item(OP_PUSH_DATA, 3, 8'ha5);
		send_item(OP_POP_HDR, 0, 8'h00);
		send_item(OP_POP_DATA, 0, 8'h00);
		send_item(OP_POP_HDR, 1, 8'h00);
		send_item(OP_POP_DATA, 0, 8'h00);
		// A pop left half done is read again from its header.
		send_item(OP_POP_HDR, MAX_LEN, 8'h00);
		send_item(OP_POP_DATA, 0, 8'h00);
		send_item(OP_POP_HDR, 2, 8'hff);
		send_item(OP_POP_DATA, MAX_LEN, 8'hff);
		send_item(OP_POP_DATA, 0, 8'h00);
		send_item(OP_POP_HDR, 3, 8'h00);
		directed_items = items_sent;

		while (items_sent < directed_items + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				rec_len = ($urandom_range(0, 6) == 0) ? $urandom_range(17, 200) :
					$urandom_range(1, 16);
				send_item(OP_PUSH_HDR, rec_len, 8'($urandom));
				if (fill_est + HDR_BYTES + rec_len > RING_BYTES) begin
					wr_open = 1'b0;
				end else begin
					n_data = ($urandom_range(0, 11) == 0) ? $urandom_range(0, rec_len - 1) : rec_len;
					for (k = 0; k < n_data; k++)
						send_item(OP_PUSH_DATA, $urandom_range(0, MAX_LEN), 8'($urandom));
					wr_open = (n_data != rec_len);
					if (!wr_open) begin
						rec_lengths.push_back(rec_len);
						fill_est += HDR_BYTES + rec_len;
						records_pushed++;
					end
				end
			end else if (pick < 75) begin
				if (rec_lengths.size() == 0) begin
					send_item(OP_POP_HDR, $urandom_range(0, MAX_LEN), 8'($urandom));
					rd_open = 1'b0;
				end else begin
					rec_len = rec_lengths[0];
					if ($urandom_range(0, 3) == 0) begin
						send_item(OP_POP_HDR, $urandom_range(0, rec_len - 1), 8'($urandom));
						rd_open = 1'b0;
					end else begin
						send_item(OP_POP_HDR, $urandom_range(rec_len, MAX_LEN), 8'($urandom));
						n_data = ($urandom_range(0, 11) == 0) ? $urandom_range(0, rec_len - 1) :
							rec_len;
						for (k = 0; k < n_data; k++)
							send_item(OP_POP_DATA, $urandom_range(0, MAX_LEN), 8'($urandom));
						rd_open = (n_data != rec_len);
						if (!rd_open) begin
							void'(rec_lengths.pop_front());
							fill_est -= HDR_BYTES + rec_len;
							records_popped++;
						end
					end
				end
			end else if (pick < 85) begin
				// Stray data transfers, only on a side with no record open; with both open, a zero-length header.
				if (!wr_open && (rd_open || $urandom_range(0, 1) == 0)) begin
					send_item(OP_PUSH_DATA, $urandom_range(0, MAX_LEN), 8'($urandom));
				end else if (!rd_open) begin
					send_item(OP_POP_DATA, $urandom_range(0, MAX_LEN), 8'($urandom));
				end else begin
					send_item(OP_PUSH_HDR, 0, 8'($urandom));
					wr_open = 1'b0;
				end
			end else if (pick < 93) begin
				send_item(OP_PUSH_HDR, 0, 8'($urandom));
				wr_open = 1'b0;
			end else begin
				len_min = RING_BYTES - HDR_BYTES - fill_est + 1;
				if (len_min <= MAX_LEN)
					send_item(OP_PUSH_HDR, $urandom_range(len_min, MAX_LEN), 8'($urandom));
				else
					send_item(OP_PUSH_HDR, 0, 8'($urandom));
				wr_open = 1'b0;
			end
		end

		start <= 1'b0;
		drain = 0;
		do begin
			@(negedge clk);
			drain++;
		end while (replies_waiting != 0 && drain < 2000);
		repeat (20) @(negedge clk);

		if (replies_waiting != 0)
			$error("%0d replies never arrived", replies_waiting);
		$display("Sent %0d transfers (%0d directed), %0d replies compared.",
			items_sent, directed_items, replies_checked);
		$display("Records completed: %0d pushed, %0d popped, %0d bytes left in the ring.",
			records_pushed, records_popped, fill_est);
		if (mismatches == 0 && replies_waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
